// ----- rtl/nnsb_pkg.sv -----
// Shared constants, codes and pixel conversion functions of the scaler.
package nnsb_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int DIM_W       = 10;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int PITCH_W     = 16;
  localparam int ADDR_W      = 32;
  localparam int WORD_W      = 32;
  localparam int EXTENT_W    = 2 * DIM_W;
  localparam int BCNT_W      = 3;
  localparam int FMT_W       = 2;
  localparam int FMTS_W      = 2 * FMT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OFS_W       = DIM_W + BCNT_W;
  localparam int MULP_W      = PITCH_W + DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PITCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_EXTENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_EXTENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMATS    = 3'd6;

  localparam logic [FMT_W-1:0] FMT_ARGB8888 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB888   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd2;
  localparam logic [FMT_W-1:0] FMT_L8       = 2'd3;

  localparam logic CMD_FETCH  = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  function automatic logic [BCNT_W-1:0] bytes_of(input logic [FMT_W-1:0] fmt);
    return BCNT_W'(3'd4 - {1'b0, fmt});
  endfunction

  function automatic logic [WORD_W-1:0] to_argb(input logic [WORD_W-1:0] c,
                                                input logic [FMT_W-1:0] fmt);
    logic [WORD_W-1:0] a;
    unique case (fmt)
      FMT_ARGB8888: a = c;
      FMT_RGB888:   a = 32'hff00_0000 | c;
      FMT_RGB565:   a = {8'hff, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
      default:      a = {8'hff, c[7:0], c[7:0], c[7:0]};
    endcase
    return a;
  endfunction

  function automatic logic [WORD_W-1:0] from_argb(input logic [WORD_W-1:0] a,
                                                  input logic [FMT_W-1:0] fmt);
    logic [WORD_W-1:0] v;
    unique case (fmt)
      FMT_ARGB8888: v = a;
      FMT_RGB888:   v = a & 32'h00ff_ffff;
      FMT_RGB565:   v = {16'h0000, a[23:19], a[15:10], a[7:3]};
      default:      v = {24'h00_0000, a[7:0]};
    endcase
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] convert(input logic [WORD_W-1:0] c,
                                                input logic [FMT_W-1:0] sf,
                                                input logic [FMT_W-1:0] df);
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] m;
    v = (sf == df) ? c : from_argb(to_argb(c, sf), df);
    unique case (df)
      FMT_ARGB8888: m = 32'hffff_ffff;
      FMT_RGB888:   m = 32'h00ff_ffff;
      FMT_RGB565:   m = 32'h0000_ffff;
      default:      m = 32'h0000_00ff;
    endcase
    return v & m;
  endfunction

endpackage

// ----- rtl/nnsb_in_if.sv -----
// Input item channel: command and fetched pixel word.
interface nnsb_in_if import nnsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] pixel_word;

  modport source (output valid, output cmd, output pixel_word, input ready);
  modport sink   (input valid, input cmd, input pixel_word, output ready);
endinterface

// ----- rtl/nnsb_out_if.sv -----
// Result item channel: read address or destination write.
interface nnsb_out_if import nnsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] pixel_out;
  logic [BCNT_W-1:0] byte_count;
  logic              last;

  modport source (output valid, output kind, output address, output pixel_out,
                  output byte_count, output last, input ready);
  modport sink   (input valid, input kind, input address, input pixel_out,
                  input byte_count, input last, output ready);
endinterface

// ----- rtl/nnsb_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module nnsb_div import nnsb_pkg::*; #(
  parameter int NUM_W = PROD_W,
  parameter int DEN_W = DIM_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/nearest_neighbour_scale_blit.sv -----
// Top level of the nearest-neighbor rectangle scaler with pixel format conversion.
//
// Configure through cfg_we/cfg_index/cfg_data while idle; any write restarts
// both rectangle walkers. Each input item on in_ch is a fetch request (cmd 0)
// or a fetched source word (cmd 1). A fetch request returns the source read
// address on out_ch; a word returns the destination address, the converted
// pixel and its byte count. last marks the final fetch or write of the
// rectangle; later requests of that kind, and all requests while the
// destination size is zero, return nothing.
// A fetch passes twice through the shared bit-serial divider (20 quotient
// bits each, source x then source y), then a pitch multiply, an address add,
// the output load and the return to idle. A word takes only the multiply,
// add, load and idle steps.
// One item is in work at a time; in_ch.ready is high while the sequencer is
// idle. Results sit in an output register, so a stalled receiver holds the
// result while the next item is accepted and processed; the sequencer waits
// only when a second result is ready before the first is taken.
// Reset clears the sequencer, the walkers, the configuration registers and the output valid.
module nearest_neighbour_scale_blit import nnsb_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nnsb_in_if.sink               in_ch,
  nnsb_out_if.source            out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIVX = 6'b000010,
    ST_DIVY = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] f);
    logic [DIM_W-1:0] d;
    d = f;
    if (int'(f) >= MAX_DIMENSION) begin
      d = DIM_W'(MAX_DIMENSION - 1);
    end
    return d;
  endfunction

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]   src_origin_r, dst_origin_r;
  logic [PITCH_W-1:0]  src_pitch_r, dst_pitch_r;
  logic [EXTENT_W-1:0] src_extent_r, dst_extent_r;
  logic [FMTS_W-1:0]   formats_r;

  logic [DIM_W-1:0] fetch_col_r, fetch_row_r, write_col_r, write_row_r;
  logic             fetch_fin_r, write_fin_r;
  logic [DIM_W-1:0] fetch_col_nxt, fetch_row_nxt, write_col_nxt, write_row_nxt;
  logic             fetch_fin_nxt, write_fin_nxt;

  logic             kind_r, last_r;
  logic [DIM_W-1:0] col_op_r, row_op_r;
  logic [WORD_W-1:0] pix_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [MULP_W-1:0] prod_r;
  logic [ADDR_W-1:0] addr_r;

  logic              out_valid_r, out_kind_r, out_last_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [WORD_W-1:0] out_pix_r;
  logic [BCNT_W-1:0] out_bcnt_r;

  logic [DIM_W-1:0] dw, dh, sw, sh;
  logic [FMT_W-1:0] sf, df;
  logic             accept, produce, out_load;
  logic [DIM_W-1:0] sel_col, sel_row, adv_col, adv_row;
  logic             fin;

  logic              div_start, div_done;
  logic [DIM_W-1:0]  mul_a, mul_b, div_den;
  logic [PROD_W-1:0] div_num, div_quo;
  logic [PITCH_W-1:0] pitch;
  logic [BCNT_W-1:0]  bytes;
  logic [OFS_W-1:0]   offs;

  assign dw = dim_sat(dst_extent_r[DIM_W-1:0]);
  assign dh = dim_sat(dst_extent_r[EXTENT_W-1:DIM_W]);
  assign sw = dim_sat(src_extent_r[DIM_W-1:0]);
  assign sh = dim_sat(src_extent_r[EXTENT_W-1:DIM_W]);
  assign sf = formats_r[FMTS_W-1:FMT_W];
  assign df = formats_r[FMT_W-1:0];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign produce     = accept && (dw != '0) && (dh != '0) &&
                       ((in_ch.cmd == CMD_FETCH) ? !fetch_fin_r : !write_fin_r);
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Walker step for the selected command.
  always_comb begin
    sel_col = (in_ch.cmd == CMD_WRITE) ? write_col_r : fetch_col_r;
    sel_row = (in_ch.cmd == CMD_WRITE) ? write_row_r : fetch_row_r;
    fin     = (sel_col == DIM_W'(dw - 1'b1)) && (sel_row == DIM_W'(dh - 1'b1));
    if (({1'b0, sel_col} + 1'b1) >= {1'b0, dw}) begin
      adv_col = '0;
      adv_row = DIM_W'(sel_row + 1'b1);
    end else begin
      adv_col = DIM_W'(sel_col + 1'b1);
      adv_row = sel_row;
    end
  end

  always_comb begin
    fetch_col_nxt = fetch_col_r;
    fetch_row_nxt = fetch_row_r;
    fetch_fin_nxt = fetch_fin_r;
    write_col_nxt = write_col_r;
    write_row_nxt = write_row_r;
    write_fin_nxt = write_fin_r;
    if (cfg_we) begin
      fetch_col_nxt = '0;
      fetch_row_nxt = '0;
      fetch_fin_nxt = 1'b0;
      write_col_nxt = '0;
      write_row_nxt = '0;
      write_fin_nxt = 1'b0;
    end else if (produce) begin
      if (in_ch.cmd == CMD_WRITE) begin
        write_col_nxt = adv_col;
        write_row_nxt = adv_row;
        write_fin_nxt = fin;
      end else begin
        fetch_col_nxt = adv_col;
        fetch_row_nxt = adv_row;
        fetch_fin_nxt = fin;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (produce) begin
          state_nxt = (in_ch.cmd == CMD_WRITE) ? ST_MUL : ST_DIVX;
        end
      end
      ST_DIVX: if (div_done) state_nxt = ST_DIVY;
      ST_DIVY: if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Shared divider operands: source x at acceptance, source y after x.
  assign mul_a     = (state_r == ST_IDLE) ? fetch_col_r : row_op_r;
  assign mul_b     = (state_r == ST_IDLE) ? sw : sh;
  assign div_den   = (state_r == ST_IDLE) ? dw : dh;
  assign div_num   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign div_start = (produce && (in_ch.cmd == CMD_FETCH)) ||
                     ((state_r == ST_DIVX) && div_done);

  nnsb_div #(
    .NUM_W (PROD_W),
    .DEN_W (DIM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign pitch = (kind_r == KIND_WRITE) ? dst_pitch_r : src_pitch_r;
  assign bytes = bytes_of((kind_r == KIND_WRITE) ? df : sf);
  assign offs  = OFS_W'(col_op_r) * OFS_W'(bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_origin_r <= '0;
      src_pitch_r  <= '0;
      dst_origin_r <= '0;
      dst_pitch_r  <= '0;
      src_extent_r <= '0;
      dst_extent_r <= '0;
      formats_r    <= '0;
      fetch_col_r  <= '0;
      fetch_row_r  <= '0;
      fetch_fin_r  <= 1'b0;
      write_col_r  <= '0;
      write_row_r  <= '0;
      write_fin_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fetch_col_r <= fetch_col_nxt;
      fetch_row_r <= fetch_row_nxt;
      fetch_fin_r <= fetch_fin_nxt;
      write_col_r <= write_col_nxt;
      write_row_r <= write_row_nxt;
      write_fin_r <= write_fin_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SRC_ORIGIN: src_origin_r <= cfg_data;
          CFG_SRC_PITCH:  src_pitch_r  <= cfg_data[PITCH_W-1:0];
          CFG_DST_ORIGIN: dst_origin_r <= cfg_data;
          CFG_DST_PITCH:  dst_pitch_r  <= cfg_data[PITCH_W-1:0];
          CFG_SRC_EXTENT: src_extent_r <= cfg_data[EXTENT_W-1:0];
          CFG_DST_EXTENT: dst_extent_r <= cfg_data[EXTENT_W-1:0];
          CFG_FORMATS:    formats_r    <= cfg_data[FMTS_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      kind_r   <= in_ch.cmd;
      last_r   <= fin;
      col_op_r <= sel_col;
      row_op_r <= sel_row;
      pix_r    <= (in_ch.cmd == CMD_WRITE) ? convert(in_ch.pixel_word, sf, df) : '0;
      bcnt_r   <= (in_ch.cmd == CMD_WRITE) ? bytes_of(df) : '0;
    end
    if ((state_r == ST_DIVX) && div_done) begin
      col_op_r <= div_quo[DIM_W-1:0];
    end
    if ((state_r == ST_DIVY) && div_done) begin
      row_op_r <= div_quo[DIM_W-1:0];
    end
    if (state_r == ST_MUL) begin
      prod_r <= MULP_W'(row_op_r) * MULP_W'(pitch);
    end
    if (state_r == ST_SUM) begin
      addr_r <= ADDR_W'(((kind_r == KIND_WRITE) ? dst_origin_r : src_origin_r) +
                        ADDR_W'(prod_r) + ADDR_W'(offs));
    end
    if (out_load) begin
      out_kind_r <= kind_r;
      out_addr_r <= addr_r;
      out_pix_r  <= pix_r;
      out_bcnt_r <= bcnt_r;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.address    = out_addr_r;
  assign out_ch.pixel_out  = out_pix_r;
  assign out_ch.byte_count = out_bcnt_r;
  assign out_ch.last       = out_last_r;

endmodule

// ----- dv/nnsb_blit_checker.sv -----
`timescale 1ns / 100ps
// Checker for the scaler: tracks registers and both walkers, predicts result items, compares them.
module nnsb_blit_checker import nnsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  nnsb_in_if                    in_mon,
  nnsb_out_if                   out_mon,
  output int                    fail_count,
  output int                    owed_count,
  output int                    checked_count
);

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] pixel_out;
    logic [BCNT_W-1:0] byte_count;
    logic              last;
  } blit_result_t;

  blit_result_t owed_results[$];

  logic [ADDR_W-1:0]   src_origin, dst_origin;
  logic [PITCH_W-1:0]  src_pitch, dst_pitch;
  logic [EXTENT_W-1:0] src_extent, dst_extent;
  logic [FMTS_W-1:0]   formats;
  logic [DIM_W-1:0]    fetch_col, fetch_row, write_col, write_row;
  logic                fetch_done, write_done;
  int                  fails = 0;
  int                  checked = 0;

  function automatic logic [BCNT_W-1:0] pixel_bytes(input logic [FMT_W-1:0] fmt);
    return BCNT_W'(4 - int'(fmt));
  endfunction

  function automatic logic [WORD_W-1:0] recode_pixel(input logic [WORD_W-1:0] c,
                                                     input logic [FMT_W-1:0]  sf,
                                                     input logic [FMT_W-1:0]  df);
    logic [WORD_W-1:0] argb;
    logic [WORD_W-1:0] v;
    unique case (sf)
      FMT_ARGB8888: argb = c;
      FMT_RGB888:   argb = {8'hff, c[23:0]};
      FMT_RGB565:   argb = 32'hff00_0000 | ((c & 32'h1f) << 3) | ((c & 32'h7e0) << 5) |
                           ((c & 32'hf800) << 8);
      default:      argb = {8'hff, c[7:0], c[7:0], c[7:0]};
    endcase
    unique case (df)
      FMT_ARGB8888: v = argb;
      FMT_RGB888:   v = {8'h00, argb[23:0]};
      FMT_RGB565:   v = ((argb & 32'hf8) >> 3) | ((argb & 32'hfc00) >> 5) |
                        ((argb & 32'hf8_0000) >> 8);
      default:      v = {24'h00_0000, argb[7:0]};
    endcase
    if (sf == df) v = c;
    if (df != FMT_ARGB8888) v = v & ~(32'hffff_ffff << (8 * int'(pixel_bytes(df))));
    return v;
  endfunction

  function automatic logic advance_walker(inout logic [DIM_W-1:0] col,
                                          inout logic [DIM_W-1:0] row,
                                          input logic [DIM_W-1:0] w,
                                          input logic [DIM_W-1:0] h);
    logic fin;
    fin = (col == w - 1'b1) && (row == h - 1'b1);
    if (int'(col) + 1 >= int'(w)) begin
      col = '0;
      row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
    return fin;
  endfunction

  function automatic void clear_walkers();
    fetch_col  = '0;
    fetch_row  = '0;
    write_col  = '0;
    write_row  = '0;
    fetch_done = 1'b0;
    write_done = 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    blit_result_t     r;
    blit_result_t     want;
    logic [DIM_W-1:0] dw, dh, sw, sh, sx, sy;
    logic [FMT_W-1:0] sf, df;
    if (!rst_n) begin
      src_origin = '0;
      src_pitch  = '0;
      dst_origin = '0;
      dst_pitch  = '0;
      src_extent = '0;
      dst_extent = '0;
      formats    = '0;
      clear_walkers();
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SRC_ORIGIN: src_origin = cfg_data;
          CFG_SRC_PITCH:  src_pitch  = cfg_data[PITCH_W-1:0];
          CFG_DST_ORIGIN: dst_origin = cfg_data;
          CFG_DST_PITCH:  dst_pitch  = cfg_data[PITCH_W-1:0];
          CFG_SRC_EXTENT: src_extent = cfg_data[EXTENT_W-1:0];
          CFG_DST_EXTENT: dst_extent = cfg_data[EXTENT_W-1:0];
          CFG_FORMATS:    formats    = cfg_data[FMTS_W-1:0];
          default: ;
        endcase
        clear_walkers();
      end

      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (owed_results.size() == 0) begin
          $error("result item with no prediction: kind %0d address 0x%0h",
                 out_mon.kind, out_mon.address);
          fails++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", WORD_W'(want.kind), WORD_W'(out_mon.kind));
          check_field("address", want.address, out_mon.address);
          check_field("pixel_out", want.pixel_out, out_mon.pixel_out);
          check_field("byte_count", WORD_W'(want.byte_count), WORD_W'(out_mon.byte_count));
          check_field("last", WORD_W'(want.last), WORD_W'(out_mon.last));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        dw = dst_extent[DIM_W-1:0];
        dh = dst_extent[EXTENT_W-1:DIM_W];
        sw = src_extent[DIM_W-1:0];
        sh = src_extent[EXTENT_W-1:DIM_W];
        sf = formats[FMTS_W-1:FMT_W];
        df = formats[FMT_W-1:0];
        if (dw != '0 && dh != '0) begin
          if (in_mon.cmd == CMD_FETCH && !fetch_done) begin
            sx = DIM_W'((PROD_W'(fetch_col) * PROD_W'(sw)) / PROD_W'(dw));
            sy = DIM_W'((PROD_W'(fetch_row) * PROD_W'(sh)) / PROD_W'(dh));
            r.kind       = KIND_READ;
            r.address    = src_origin + ADDR_W'(sy) * ADDR_W'(src_pitch) +
                           ADDR_W'(sx) * ADDR_W'(pixel_bytes(sf));
            r.pixel_out  = '0;
            r.byte_count = '0;
            fetch_done   = advance_walker(fetch_col, fetch_row, dw, dh);
            r.last       = fetch_done;
            owed_results.push_back(r);
          end else if (in_mon.cmd == CMD_WRITE && !write_done) begin
            r.kind       = KIND_WRITE;
            r.address    = dst_origin + ADDR_W'(write_row) * ADDR_W'(dst_pitch) +
                           ADDR_W'(write_col) * ADDR_W'(pixel_bytes(df));
            r.pixel_out  = recode_pixel(in_mon.pixel_word, sf, df);
            r.byte_count = pixel_bytes(df);
            write_done   = advance_walker(write_col, write_row, dw, dh);
            r.last       = write_done;
            owed_results.push_back(r);
          end
        end
      end
    end
    owed_count    <= owed_results.size();
    fail_count    <= fails;
    checked_count <= checked;
  end

endmodule

// ----- dv/tb_nearest_neighbour_scale_blit.sv -----
`timescale 1ns / 100ps
// Testbench top for the scaler: reset, register settings, item stimulus and the verdict.
module tb_nearest_neighbour_scale_blit;
  import nnsb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NOWHERE = 3'd7;
  localparam int ITEM_GOAL    = 850;
  localparam int DRAIN_CYCLES = 64;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;
  int                    fails, owed, checked;
  int                    sent = 0;
  int                    random_sent = 0;
  int                    settings = 0;

  nnsb_in_if  in_ch ();
  nnsb_out_if out_ch ();

  nearest_neighbour_scale_blit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  nnsb_blit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fails),
    .owed_count    (owed),
    .checked_count (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && (calm || ($urandom_range(0, 99) >= 33));
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [WORD_W-1:0] random_word();
    unique case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [WORD_W-1:0] word);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.pixel_word <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic finish_program();
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic write_all(input logic [ADDR_W-1:0] src_org, input logic [PITCH_W-1:0] src_p,
                           input logic [ADDR_W-1:0] dst_org, input logic [PITCH_W-1:0] dst_p,
                           input logic [EXTENT_W-1:0] src_ext,
                           input logic [EXTENT_W-1:0] dst_ext,
                           input logic [FMTS_W-1:0] fmts);
    program_reg(CFG_SRC_ORIGIN, src_org);
    program_reg(CFG_SRC_PITCH, 32'(src_p));
    program_reg(CFG_DST_ORIGIN, dst_org);
    program_reg(CFG_DST_PITCH, 32'(dst_p));
    program_reg(CFG_SRC_EXTENT, 32'(src_ext));
    program_reg(CFG_DST_EXTENT, 32'(dst_ext));
    program_reg(CFG_FORMATS, 32'(fmts));
    finish_program();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // keep fetches ahead of writes, as a real blit engine would
  task automatic walk_rectangle(input int pixels);
    int fetched;
    int written;
    fetched = 0;
    written = 0;
    while (fetched < pixels || written < pixels) begin
      if (written >= fetched || (fetched < pixels && $urandom_range(0, 1) == 0)) begin
        send_item(CMD_FETCH, $urandom);
        fetched++;
      end else begin
        send_item(CMD_WRITE, random_word());
        written++;
      end
    end
  endtask

  initial begin
    logic [DIM_W-1:0] dw, dh, sw, sh;
    int               pick;
    int               pixels;
    int               noise;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_FETCH;
    in_ch.pixel_word <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero destination size after reset: nothing comes back
    send_item(CMD_FETCH, 32'h0000_0000);
    send_item(CMD_WRITE, 32'hffff_ffff);
    settle();

    write_all(32'hffff_fff8, 16'hffff, 32'hffff_fffc, 16'hffff, {10'd1023, 10'd1023},
              {10'd2, 10'd2}, {FMT_ARGB8888, FMT_ARGB8888});
    repeat (5) send_item(CMD_FETCH, 32'hffff_ffff);
    send_item(CMD_WRITE, 32'hffff_ffff);
    send_item(CMD_WRITE, 32'h0000_0000);
    send_item(CMD_WRITE, 32'ha5c3_5a3c);
    send_item(CMD_WRITE, 32'h5a3c_a5c3);
    send_item(CMD_WRITE, 32'h1234_5678);
    settle();

    program_reg(CFG_SRC_EXTENT, 32'h0);
    program_reg(CFG_DST_EXTENT, {12'h000, 10'd1, 10'd3});
    program_reg(CFG_FORMATS, {28'h0, FMT_L8, FMT_RGB565});
    finish_program();
    walk_rectangle(3);
    settle();

    write_all(32'h0, 16'h0, 32'h0, 16'h0, {10'd500, 10'd7}, {10'd1023, 10'd1023},
              {FMT_RGB565, FMT_RGB888});
    walk_rectangle(2);
    settle();
    program_reg(CFG_NOWHERE, $urandom);
    finish_program();
    walk_rectangle(1);
    settle();

    while (random_sent < ITEM_GOAL) begin
      calm = (random_sent >= 380 && random_sent < 520);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        dw = ($urandom_range(0, 1) == 0) ? 10'd0 : DIM_W'($urandom);
        dh = (dw == '0) ? DIM_W'($urandom) : 10'd0;
      end else if (pick < 14) begin
        if ($urandom_range(0, 1) == 0) begin
          dw = 10'd1023;
          dh = DIM_W'($urandom_range(1, 3));
        end else begin
          dw = DIM_W'($urandom_range(1, 3));
          dh = 10'd1023;
        end
      end else begin
        dw = DIM_W'($urandom_range(1, 6));
        dh = DIM_W'($urandom_range(1, 5));
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        {sh, sw} = EXTENT_W'($urandom);
      end else if (pick < 35) begin
        sw = DIM_W'($urandom_range(0, 12));
        sh = (sw == '0) ? DIM_W'($urandom_range(0, 12)) : 10'd0;
      end else begin
        sw = DIM_W'($urandom_range(1, 12));
        sh = DIM_W'($urandom_range(1, 12));
      end
      write_all($urandom, PITCH_W'($urandom), $urandom, PITCH_W'($urandom), {sh, sw},
                {dh, dw}, FMTS_W'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        program_reg(CFG_NOWHERE, $urandom);
        finish_program();
      end

      pixels = int'(dw) * int'(dh);
      if (pixels == 0) begin
        repeat ($urandom_range(2, 6)) send_item(1'($urandom_range(0, 1)), random_word());
      end else if (pixels > 64) begin
        pixels = $urandom_range(3, 12);
        walk_rectangle(pixels);
        random_sent += 2 * pixels;
      end else if ($urandom_range(0, 9) == 0) begin
        noise = $urandom_range(1, 2 * pixels + 4);
        repeat (noise) send_item(1'($urandom_range(0, 1)), random_word());
        random_sent += noise;
      end else begin
        walk_rectangle(pixels);
        random_sent += 2 * pixels;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), random_word());
        end
      end
      settle();
    end
    calm = 1'b0;

    $display("Ran %0d register settings with %0d input items, %0d of them random.",
             settings, sent, random_sent);
    $display("Compared %0d result items against the predicted rectangle walk.", checked);
    if (fails == 0 && owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
